FILE: hw/rtl/line_raster_framebuffer_macros.svh
// assertion helpers for the line raster framebuffer
// each check runs on the rising edge of clk and is off while arst_n is low
`ifndef LINE_RASTER_FRAMEBUFFER_MACROS_SVH
`define LINE_RASTER_FRAMEBUFFER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LRF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("line raster framebuffer check failed");

// next-cycle implication
`define LRF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("line raster framebuffer check failed");

`else

`define LRF_ASSERT_NOW(label, ante, cons)
`define LRF_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hw/rtl/lrf_pkg.sv
package lrf_pkg;

	// default geometry
	localparam int SCREEN_COLUMNS_DEF = 128;
	localparam int SCREEN_PAGES_DEF   = 8;
	localparam int MAX_THICKNESS_DEF  = 8;

	// rows per page byte
	localparam int PAGE_ROWS = 8;

	// working widths fixed by the 7-bit column, 6-bit row and 4-bit thickness fields
	localparam int COL_W   = 7;
	localparam int ROW_W   = 6;
	localparam int THK_W   = 4;
	localparam int COORD_W = 9;
	localparam int ERR_W   = 10;

	// request codes
	typedef enum logic [1:0] {
		ACT_DRAW  = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_READ  = 2'd2
	} action_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [COL_W-1:0] start_col;
		logic [ROW_W-1:0] start_row;
		logic [COL_W-1:0] end_col;
		logic [ROW_W-1:0] end_row;
		logic [THK_W-1:0] thickness;
		logic [9:0]       read_address;
	} request_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       clipped;
	} result_t;

	// controller states
	typedef enum logic [2:0] {
		ST_INIT_SWEEP,
		ST_IDLE,
		ST_DRAW_CHECK,
		ST_PIX_RD,
		ST_PIX_WR,
		ST_CLEAR_SWEEP,
		ST_FINISH
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic pix_rd;
		logic pix_wr;
		logic advance;
		logic sweep;
		logic emit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic thick_zero;
		logic off_screen;
		logic last_t;
		logic line_end;
		logic sweep_last;
	} dp_status_t;

endpackage

FILE: hw/rtl/lrf_store.sv
module lrf_store #(
	parameter int DEPTH  = lrf_pkg::SCREEN_COLUMNS_DEF * lrf_pkg::SCREEN_PAGES_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);
	import lrf_pkg::*;

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/lrf_ctrl.sv
module lrf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          action,
	input  lrf_pkg::dp_status_t status,
	output lrf_pkg::dp_cmd_t    cmd,
	output logic                busy,
	output logic                done
);
	import lrf_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        done_q;

	// state register and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT_SWEEP;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.emit;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			ST_INIT_SWEEP: begin
				cmd.sweep = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					case (action)
						ACT_DRAW:  state_d = ST_DRAW_CHECK;
						ACT_CLEAR: state_d = ST_CLEAR_SWEEP;
						default:   state_d = ST_FINISH;
					endcase
				end
			end
			ST_DRAW_CHECK: begin
				state_d = status.thick_zero ? ST_FINISH : ST_PIX_RD;
			end
			ST_PIX_RD: begin
				if (status.off_screen) begin
					cmd.advance = 1'b1;
					if (status.last_t && status.line_end) begin
						state_d = ST_FINISH;
					end
				end else begin
					cmd.pix_rd = 1'b1;
					state_d    = ST_PIX_WR;
				end
			end
			ST_PIX_WR: begin
				cmd.pix_wr  = 1'b1;
				cmd.advance = 1'b1;
				state_d     = (status.last_t && status.line_end) ? ST_FINISH : ST_PIX_RD;
			end
			ST_CLEAR_SWEEP: begin
				cmd.sweep = 1'b1;
				if (status.sweep_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.emit = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign done = done_q;

endmodule

FILE: hw/rtl/lrf_datapath.sv
module lrf_datapath #(
	parameter int SCREEN_COLUMNS = lrf_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_PAGES   = lrf_pkg::SCREEN_PAGES_DEF,
	parameter int MAX_THICKNESS  = lrf_pkg::MAX_THICKNESS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lrf_pkg::request_t   request,
	input  lrf_pkg::dp_cmd_t    cmd,
	output lrf_pkg::dp_status_t status,
	output lrf_pkg::result_t    result
);
	import lrf_pkg::*;

	localparam int STORE_BYTES = SCREEN_COLUMNS * SCREEN_PAGES;
	localparam int SCREEN_ROWS = SCREEN_PAGES * PAGE_ROWS;
	localparam int ADDR_W      = $clog2(STORE_BYTES);
	localparam int THICK_W     = $clog2(MAX_THICKNESS + 1);

	// line walk registers
	logic [COL_W-1:0]        x_q, x_end_q;
	logic [ROW_W-1:0]        y_q, y_end_q;
	logic [COL_W-1:0]        adx_q;
	logic [ROW_W-1:0]        ady_q;
	logic                    sy_up_q;
	logic                    vert_q;
	logic signed [ERR_W-1:0] err_q;
	logic [THICK_W-1:0]      thick_q, t_q;
	logic                    clip_q;
	logic                    read_sel_q, read_ok_q;
	logic [ADDR_W-1:0]       sweep_q;
	result_t                 result_q;

	// endpoint setup from the request
	logic                    swap;
	logic [COL_W-1:0]        ax, bx, dx;
	logic [ROW_W-1:0]        ay, by, ady, lo_row, hi_row;
	logic signed [ERR_W-1:0] err_init;
	logic [THK_W:0]          thick_wide;
	logic [THICK_W-1:0]      thick_sat;

	always_comb begin
		swap     = request.end_col < request.start_col;
		ax       = swap ? request.end_col : request.start_col;
		bx       = swap ? request.start_col : request.end_col;
		ay       = swap ? request.end_row : request.start_row;
		by       = swap ? request.start_row : request.end_row;
		dx       = bx - ax;
		ady      = (by >= ay) ? (by - ay) : (ay - by);
		lo_row   = (ay < by) ? ay : by;
		hi_row   = (ay < by) ? by : ay;
		if ({1'b0, dx} > {2'b00, ady}) begin
			err_init = signed'(ERR_W'(dx >> 1));
		end else begin
			err_init = -signed'(ERR_W'(ady >> 1));
		end
		thick_wide = {1'b0, request.thickness};
		if (int'(thick_wide) > MAX_THICKNESS) begin
			thick_sat = THICK_W'(MAX_THICKNESS);
		end else begin
			thick_sat = THICK_W'(thick_wide);
		end
	end

	// current pixel and its byte
	logic [COORD_W-1:0] px, py;
	logic               off_screen;
	logic [ADDR_W-1:0]  pix_addr;
	logic [7:0]         pix_bit;

	always_comb begin
		px         = COORD_W'(x_q) + (vert_q ? COORD_W'(t_q) : COORD_W'(0));
		py         = COORD_W'(y_q) + (vert_q ? COORD_W'(0) : COORD_W'(t_q));
		off_screen = (int'(px) >= SCREEN_COLUMNS) || (int'(py) >= SCREEN_ROWS);
		pix_addr   = ADDR_W'(int'(py[COORD_W-1:3]) * SCREEN_COLUMNS + int'(px));
		pix_bit    = 8'(1) << py[2:0];
	end

	// bresenham decisions
	logic signed [ERR_W-1:0] adx_s, ady_s;
	logic                    step_x, step_y;

	always_comb begin
		adx_s  = signed'(ERR_W'(adx_q));
		ady_s  = signed'(ERR_W'(ady_q));
		step_x = err_q > -adx_s;
		step_y = err_q < ady_s;
	end

	// store ports
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [7:0]        mem_wdata, mem_rdata;

	always_comb begin
		mem_we    = cmd.pix_wr || cmd.sweep;
		mem_waddr = cmd.sweep ? sweep_q : pix_addr;
		mem_wdata = cmd.sweep ? 8'h00 : (mem_rdata | pix_bit);
		mem_re    = cmd.load || cmd.pix_rd;
		mem_raddr = cmd.load ? ADDR_W'(request.read_address) : pix_addr;
	end

	lrf_store #(
		.DEPTH (STORE_BYTES),
		.ADDR_W(ADDR_W)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// control registers: sweep counter, clip flag, read select, read address check, thickness index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q    <= '0;
			clip_q     <= 1'b0;
			read_sel_q <= 1'b0;
			read_ok_q  <= 1'b0;
			t_q        <= '0;
		end else begin
			if (cmd.load) begin
				sweep_q    <= '0;
				clip_q     <= 1'b0;
				read_sel_q <= request.action == ACT_READ;
				read_ok_q  <= int'(request.read_address) < STORE_BYTES;
				t_q        <= '0;
			end else begin
				if (cmd.sweep) begin
					sweep_q <= (int'(sweep_q) == STORE_BYTES - 1) ? '0 : sweep_q + 1'b1;
				end
				if (cmd.advance) begin
					if (off_screen) begin
						clip_q <= 1'b1;
					end
					t_q <= (t_q == thick_q - 1'b1) ? '0 : t_q + 1'b1;
				end
			end
		end
	end

	// line walk payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			vert_q  <= ax == bx;
			x_q     <= ax;
			x_end_q <= bx;
			y_q     <= (ax == bx) ? lo_row : ay;
			y_end_q <= (ax == bx) ? hi_row : by;
			adx_q   <= dx;
			ady_q   <= ady;
			sy_up_q <= by > ay;
			err_q   <= err_init;
			thick_q <= thick_sat;
		end else if (cmd.advance && (t_q == thick_q - 1'b1) && !status.line_end) begin
			if (vert_q) begin
				y_q <= y_q + 1'b1;
			end else begin
				err_q <= err_q - (step_x ? ady_s : ERR_W'(0)) + (step_y ? adx_s : ERR_W'(0));
				if (step_x) begin
					x_q <= x_q + 1'b1;
				end
				if (step_y) begin
					y_q <= sy_up_q ? (y_q + 1'b1) : (y_q - 1'b1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.read_data <= (read_sel_q && read_ok_q) ? mem_rdata : 8'h00;
			result_q.clipped   <= clip_q;
		end
	end

	always_comb begin
		status.thick_zero = thick_q == '0;
		status.off_screen = off_screen;
		status.last_t     = t_q == thick_q - 1'b1;
		status.line_end   = (x_q == x_end_q) && (y_q == y_end_q);
		status.sweep_last = int'(sweep_q) == STORE_BYTES - 1;
	end

	assign result = result_q;

endmodule

FILE: hw/rtl/line_raster_framebuffer.sv
// channel   direction  handshake          payload
// request   in         start && !busy     request (action, endpoints, thickness, address)
// result    out        done, one cycle    result (read_data, clipped)
//
// draw: each on-screen pixel is a store read then a write; a dropped pixel only advances
// clear: one store byte zeroed per cycle over all SCREEN_COLUMNS*SCREEN_PAGES bytes
// read and unused action: the request goes straight to the finish state, then done
// after reset a clearing pass over all SCREEN_COLUMNS*SCREEN_PAGES store bytes holds busy high
// the receiver cannot stall: done is a single-cycle strobe
`include "line_raster_framebuffer_macros.svh"

module line_raster_framebuffer #(
	parameter int SCREEN_COLUMNS = lrf_pkg::SCREEN_COLUMNS_DEF,
	parameter int SCREEN_PAGES   = lrf_pkg::SCREEN_PAGES_DEF,
	parameter int MAX_THICKNESS  = lrf_pkg::MAX_THICKNESS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  lrf_pkg::request_t request,
	output logic              done,
	output lrf_pkg::result_t  result
);
	import lrf_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencer
	lrf_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.action(request.action),
		.status(status),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	// line walker and frame store
	lrf_datapath #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_PAGES  (SCREEN_PAGES),
		.MAX_THICKNESS (MAX_THICKNESS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.request(request),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

	// checks
	`LRF_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`LRF_ASSERT_NEXT(a_done_single, done, !done)
	`LRF_ASSERT_NOW(a_done_idle, done, !busy)
	`LRF_ASSERT_NOW(a_data_no_clip, done && (result.read_data != 8'h00), !result.clipped)

endmodule

FILE: tb/line_raster_framebuffer_test.sv
`timescale 1ns / 1ps

module line_raster_framebuffer_test;
	import lrf_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int COLS         = SCREEN_COLUMNS_DEF;
	localparam int PAGES        = SCREEN_PAGES_DEF;
	localparam int ROWS         = PAGES * PAGE_ROWS;
	localparam int STORE_BYTES  = COLS * PAGES;
	localparam int MAX_THICK    = MAX_THICKNESS_DEF;
	localparam int RANDOM_ITEMS = 560;
	localparam int TAIL_CYCLES  = 20;
	localparam int MAX_PRINTED  = 50;
	localparam int REQ_W        = $bits(request_t);

	// action code with no meaning in the block
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct {
		request_t req;
		int       idle_pct;
	} pending_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	request_t request = '0;
	logic     done;
	result_t  result;

	pending_t   pending_requests[$];
	result_t    expected_results[$];
	logic [7:0] frame_image [STORE_BYTES];
	bit         pixels_dropped;
	result_t    oldest_result;

	int error_count = 0;
	int results_checked = 0;
	int lines_drawn = 0;
	int lines_clipped = 0;
	int bytes_read = 0;
	int bytes_read_nonzero = 0;
	int frames_cleared = 0;

	line_raster_framebuffer i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always #CLK_HALF clk = ~clk;

	task automatic report_error(input string what);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("ERROR %0t ns: %s", $time, what);
	endtask

	// frame image update, one pixel
	function automatic void plot_pixel_image(input int col, input int row);
		if (col < 0 || row < 0 || col >= COLS || row >= ROWS) begin
			pixels_dropped = 1'b1;
		end else begin
			frame_image[(row >> 3) * COLS + col] |= 8'(1 << (row & 7));
		end
	endfunction

	// line rasterization into the frame image
	function automatic void raster_line_image(input int x0, input int y0, input int x1,
			input int y1, input int thick);
		int swap_x, swap_y, lo, hi, r, t, dx, dy, ady, sy, err, e2, x, y;
		bit at_end;
		if (x1 < x0) begin
			swap_x = x0;
			swap_y = y0;
			x0 = x1;
			y0 = y1;
			x1 = swap_x;
			y1 = swap_y;
		end
		if (x0 == x1) begin
			// vertical line widens to the right
			lo = (y0 < y1) ? y0 : y1;
			hi = (y0 < y1) ? y1 : y0;
			for (r = lo; r <= hi; r++)
				for (t = 0; t < thick; t++)
					plot_pixel_image(x0 + t, r);
		end else begin
			// bresenham, each step widens downward
			dx = x1 - x0;
			dy = y1 - y0;
			ady = (dy < 0) ? -dy : dy;
			sy = (dy > 0) ? 1 : -1;
			err = ((dx > ady) ? dx : -ady) / 2;
			x = x0;
			y = y0;
			at_end = 1'b0;
			while (!at_end) begin
				for (t = 0; t < thick; t++)
					plot_pixel_image(x, y + t);
				if (x == x1 && y == y1) begin
					at_end = 1'b1;
				end else begin
					e2 = err;
					if (e2 > -dx) begin
						err -= ady;
						x += 1;
					end
					if (e2 < ady) begin
						err += dx;
						y += sy;
					end
				end
			end
		end
	endfunction

	// expected result of one accepted request, frame image updated
	function automatic void predict_request(input request_t r);
		result_t want;
		int thick, i;
		want = '0;
		case (r.action)
			ACT_DRAW: begin
				thick = (r.thickness > MAX_THICK) ? MAX_THICK : int'(r.thickness);
				pixels_dropped = 1'b0;
				raster_line_image(r.start_col, r.start_row, r.end_col, r.end_row, thick);
				want.clipped = pixels_dropped;
				lines_drawn++;
				if (pixels_dropped)
					lines_clipped++;
			end
			ACT_CLEAR: begin
				for (i = 0; i < STORE_BYTES; i++)
					frame_image[i] = '0;
				frames_cleared++;
			end
			ACT_READ: begin
				if (r.read_address < STORE_BYTES)
					want.read_data = frame_image[r.read_address];
				bytes_read++;
				if (want.read_data != '0)
					bytes_read_nonzero++;
			end
			default: ;
		endcase
		expected_results.push_back(want);
	endfunction

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				predict_request(request);
				void'(pending_requests.pop_front());
			end
			if (!(start && busy)) begin
				if (pending_requests.size() != 0 &&
						$urandom_range(99) >= pending_requests[0].idle_pct) begin
					start   <= 1'b1;
					request <= pending_requests[0].req;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_error($sformatf("result %0h/%0b with no request outstanding",
					result.read_data, result.clipped));
			end else begin
				oldest_result = expected_results.pop_front();
				results_checked++;
				if (result.read_data !== oldest_result.read_data)
					report_error($sformatf("read_data %0h, expected %0h",
						result.read_data, oldest_result.read_data));
				if (result.clipped !== oldest_result.clipped)
					report_error($sformatf("clipped %0b, expected %0b",
						result.clipped, oldest_result.clipped));
			end
		end
	end

	function automatic request_t noise_request();
		request_t r;
		r = request_t'(REQ_W'({$urandom, $urandom}));
		return r;
	endfunction

	function automatic request_t line_request(input int c0, input int r0, input int c1,
			input int r1, input int th);
		request_t r;
		r = noise_request();
		r.action    = ACT_DRAW;
		r.start_col = COL_W'(c0);
		r.start_row = ROW_W'(r0);
		r.end_col   = COL_W'(c1);
		r.end_row   = ROW_W'(r1);
		r.thickness = THK_W'(th);
		return r;
	endfunction

	function automatic request_t plain_request(input logic [1:0] act, input int addr);
		request_t r;
		r = noise_request();
		r.action       = act;
		r.read_address = 10'(addr);
		return r;
	endfunction

	function automatic int clamp(input int v, input int hi);
		return (v < 0) ? 0 : (v > hi) ? hi : v;
	endfunction

	task automatic add_item(input request_t r, input int pct);
		pending_t p;
		p.req      = r;
		p.idle_pct = pct;
		pending_requests.push_back(p);
	endtask

	// stimulus, reset and end of run
	initial begin
		int i, pct, phase, pick, off, c0, r0, c1, r1, th, col, row, addr;
		for (i = 0; i < STORE_BYTES; i++)
			frame_image[i] = '0;

		// directed: store empty after the power-up sweep
		add_item(plain_request(ACT_READ, 0), 0);
		add_item(line_request(10, 20, 10, 5, 3), 0);
		add_item(plain_request(ACT_READ, 10), 0);
		add_item(plain_request(ACT_READ, COLS + 12), 0);
		add_item(line_request(3, 3, 3, 3, 1), 0);
		add_item(line_request(0, 0, 127, 0, 8), 0);
		// anti-diagonal, endpoints given right to left
		add_item(line_request(120, 10, 100, 40, 2), 0);
		add_item(line_request(50, 63, 52, 0, 1), 0);
		// oversized thickness saturates and runs off the bottom
		add_item(line_request(0, 63, 127, 0, 15), 0);
		add_item(line_request(5, 5, 60, 60, 0), 0);
		// vertical at the right edge widens off the screen
		add_item(line_request(127, 0, 127, 63, 8), 0);
		add_item(line_request(0, 63, 127, 63, 4), 0);
		add_item(plain_request(ACT_READ, STORE_BYTES - 1), 0);
		add_item(plain_request(ACT_READ, COLS - 1), 0);
		add_item(plain_request(ACT_READ, (PAGES - 1) * COLS), 0);
		add_item(plain_request(ACT_READ, 7 * COLS + 64), 0);
		add_item(plain_request(ACT_UNUSED, 0), 0);
		add_item(plain_request(ACT_READ, 0), 0);
		add_item(plain_request(ACT_CLEAR, 0), 0);
		add_item(plain_request(ACT_READ, 0), 0);
		add_item(plain_request(ACT_READ, STORE_BYTES - 1), 0);
		add_item(line_request(64, 30, 64, 31, 9), 0);
		add_item(plain_request(ACT_READ, 3 * COLS + 64), 0);
		add_item(plain_request(ACT_READ, 3 * COLS + 71), 0);

		// random: four idle phases, the third stands for receiver stall and has no effect
		c0 = 0;
		r0 = 0;
		c1 = 0;
		r1 = 0;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			phase = i * 4 / RANDOM_ITEMS;
			pct = (phase == 1) ? 71 : (phase == 3) ? 35 : 0;
			pick = $urandom_range(99);
			if (pick < 3) begin
				add_item(plain_request(ACT_CLEAR, $urandom_range(1023)), pct);
			end else if (pick < 6) begin
				add_item(plain_request(ACT_UNUSED, $urandom_range(1023)), pct);
			end else if (pick < 45) begin
				c0 = $urandom_range(COLS - 1);
				r0 = $urandom_range(ROWS - 1);
				if ($urandom_range(4) == 0) begin
					// full span, slow
					c1 = $urandom_range(COLS - 1);
					r1 = $urandom_range(ROWS - 1);
				end else begin
					off = $urandom_range(24);
					c1 = clamp(c0 + off - 12, COLS - 1);
					off = $urandom_range(24);
					r1 = clamp(r0 + off - 12, ROWS - 1);
				end
				th = $urandom_range(15);
				add_item(line_request(c0, r0, c1, r1, th), pct);
			end else begin
				// reads mostly land near the latest line
				if ($urandom_range(9) < 6) begin
					off = $urandom_range(3);
					col = clamp(($urandom_range(1) ? c0 : c1) + off, COLS - 1);
					off = $urandom_range(7);
					row = clamp(($urandom_range(1) ? r0 : r1) + off, ROWS - 1);
					addr = (row >> 3) * COLS + col;
				end else begin
					addr = $urandom_range(1023);
				end
				add_item(plain_request(ACT_READ, addr), pct);
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (pending_requests.size() != 0 || start || expected_results.size() != 0);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("covered %0d lines (%0d clipped), %0d reads (%0d nonzero), %0d clears",
			lines_drawn, lines_clipped, bytes_read, bytes_read_nonzero, frames_cleared);
		$display("%0d results checked, %0d mismatches", results_checked, error_count);
		if (error_count == 0) begin
			$display("line_raster_framebuffer_test: done, clean");
		end else begin
			$display("line_raster_framebuffer_test: done, errors");
		end
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#50_000_000;
		$display("timeout with %0d requests and %0d results outstanding",
			pending_requests.size(), expected_results.size());
		$display("line_raster_framebuffer_test: done, errors");
		$finish;
	end

endmodule
